// File: rtl/pse_pkg.sv
// ----------------------------------------------------------------------------
// Prime sieve engine package
// Field widths, opcodes, sequencer states and the response word shared by
// the sieve controller and the top level.
// ----------------------------------------------------------------------------
package pse_pkg;

	localparam int LIMIT_W = 12;
	localparam int POS_W   = 10;
	localparam int COUNT_W = 10;
	localparam int VALUE_W = 12;

	// Walk index: one bit above the limit so that stepping past it is visible.
	localparam int IDX_W  = LIMIT_W + 1;
	// Sieving base; its square passes any 12-bit limit by the time it reaches 64.
	localparam int ROOT_W = 7;

	localparam int COUNT_MAX      = 1023;
	localparam int DEF_MAX_LIMIT  = 4095;
	localparam int DEF_LIST_DEPTH = 1024;

	localparam logic OP_RUN  = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FILL,
		S_OUTER_RD,
		S_OUTER_CHK,
		S_STRIKE,
		S_COLLECT,
		S_DRAIN,
		S_READ_WAIT,
		S_RESP
	} state_t;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [VALUE_W-1:0] value;
		logic               ok;
	} rsp_t;

endpackage

// File: rtl/pse_ram.sv
// ----------------------------------------------------------------------------
// Prime sieve engine RAM
// Single-port-write, single-port-read synchronous memory with a registered
// read port.
// ----------------------------------------------------------------------------
module pse_ram #(
	parameter int DEPTH = pse_pkg::DEF_LIST_DEPTH,
	parameter int AW    = 10,
	parameter int DW    = pse_pkg::VALUE_W
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/pse_sieve_ctrl.sv
// ----------------------------------------------------------------------------
// Prime sieve engine controller
// Sequencer that fills the flag bitmap, strikes out multiples, collects the
// surviving values into the prime list and answers list reads.
// ----------------------------------------------------------------------------
module pse_sieve_ctrl #(
	parameter int MAX_LIMIT  = pse_pkg::DEF_MAX_LIMIT,
	parameter int LIST_DEPTH = pse_pkg::DEF_LIST_DEPTH,
	parameter int FLAG_AW    = 12,
	parameter int LIST_AW    = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	output logic                        cmd_stall,
	input  logic                        operation,
	input  logic [pse_pkg::LIMIT_W-1:0] limit,
	input  logic [pse_pkg::POS_W-1:0]   position,
	output logic                        flag_we,
	output logic [FLAG_AW-1:0]          flag_waddr,
	output logic                        flag_wdata,
	output logic                        flag_re,
	output logic [FLAG_AW-1:0]          flag_raddr,
	input  logic                        flag_rdata,
	output logic                        list_we,
	output logic [LIST_AW-1:0]          list_waddr,
	output logic [pse_pkg::VALUE_W-1:0] list_wdata,
	output logic                        list_re,
	output logic [LIST_AW-1:0]          list_raddr,
	input  logic [pse_pkg::VALUE_W-1:0] list_rdata,
	output logic                        rsp_valid,
	output pse_pkg::rsp_t               rsp,
	input  logic                        rsp_take
);

	localparam int EFF_MAX  = (MAX_LIMIT < 4095) ? MAX_LIMIT : 4095;
	localparam int LIST_CAP = (LIST_DEPTH < pse_pkg::COUNT_MAX) ? LIST_DEPTH
	                                                           : pse_pkg::COUNT_MAX;
	localparam logic [pse_pkg::LIMIT_W-1:0] EFF_LIM = pse_pkg::LIMIT_W'(EFF_MAX);
	localparam logic [pse_pkg::COUNT_W-1:0] CAP     = pse_pkg::COUNT_W'(LIST_CAP);

	pse_pkg::state_t state_q, state_d;

	logic [pse_pkg::LIMIT_W-1:0] lim_q;
	logic [pse_pkg::IDX_W-1:0]   idx_q;
	logic [pse_pkg::IDX_W-1:0]   sq_q;
	logic [pse_pkg::ROOT_W-1:0]  base_q;
	logic [pse_pkg::COUNT_W-1:0] count_q;
	logic [pse_pkg::VALUE_W-1:0] value_q;
	logic                        ok_q;
	logic                        pend_s1;
	logic [pse_pkg::LIMIT_W-1:0] val_s1;

	logic [pse_pkg::LIMIT_W-1:0] lim_clamped;
	logic [pse_pkg::IDX_W-1:0]   lim_ext;
	logic [pse_pkg::IDX_W-1:0]   base_ext;
	logic [pse_pkg::IDX_W-1:0]   sq_next;
	logic                        accept;
	logic                        read_hit;

	assign lim_clamped = (limit > EFF_LIM) ? EFF_LIM : limit;
	assign lim_ext     = {1'b0, lim_q};
	assign base_ext    = pse_pkg::IDX_W'(base_q);
	// (i+1)^2 = i^2 + 2i + 1 keeps the square without a multiplier.
	assign sq_next     = sq_q + {base_ext[pse_pkg::IDX_W-2:0], 1'b0} + pse_pkg::IDX_W'(1);
	assign accept      = cmd_valid && !cmd_stall;
	assign read_hit    = position < count_q;

	assign cmd_stall = (state_q != pse_pkg::S_IDLE);
	assign rsp_valid = (state_q == pse_pkg::S_RESP);
	assign rsp.count = count_q;
	assign rsp.value = value_q;
	assign rsp.ok    = ok_q;

	// A collected word is written to the list in the cycle after its flag is read.
	assign list_we    = pend_s1 && flag_rdata && (count_q < CAP);
	assign list_waddr = count_q[LIST_AW-1:0];
	assign list_wdata = val_s1;
	assign list_raddr = position[LIST_AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pse_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		flag_we    = 1'b0;
		flag_waddr = idx_q[FLAG_AW-1:0];
		flag_wdata = 1'b0;
		flag_re    = 1'b0;
		flag_raddr = idx_q[FLAG_AW-1:0];
		list_re    = 1'b0;
		case (state_q)
			pse_pkg::S_IDLE: begin
				if (accept) begin
					if (operation == pse_pkg::OP_RUN) begin
						state_d = (lim_clamped < pse_pkg::LIMIT_W'(2)) ? pse_pkg::S_RESP
						                                                 : pse_pkg::S_FILL;
					end else if (read_hit) begin
						list_re = 1'b1;
						state_d = pse_pkg::S_READ_WAIT;
					end else begin
						state_d = pse_pkg::S_RESP;
					end
				end
			end
			pse_pkg::S_FILL: begin
				flag_we    = 1'b1;
				flag_wdata = idx_q > pse_pkg::IDX_W'(1);
				if (idx_q == lim_ext) begin
					state_d = pse_pkg::S_OUTER_RD;
				end
			end
			pse_pkg::S_OUTER_RD: begin
				if (sq_q > lim_ext) begin
					state_d = pse_pkg::S_COLLECT;
				end else begin
					flag_re    = 1'b1;
					flag_raddr = base_ext[FLAG_AW-1:0];
					state_d    = pse_pkg::S_OUTER_CHK;
				end
			end
			pse_pkg::S_OUTER_CHK: begin
				state_d = flag_rdata ? pse_pkg::S_STRIKE : pse_pkg::S_OUTER_RD;
			end
			pse_pkg::S_STRIKE: begin
				if (idx_q > lim_ext) begin
					state_d = pse_pkg::S_OUTER_RD;
				end else begin
					flag_we = 1'b1;
				end
			end
			pse_pkg::S_COLLECT: begin
				flag_re = 1'b1;
				if (idx_q == lim_ext) begin
					state_d = pse_pkg::S_DRAIN;
				end
			end
			pse_pkg::S_DRAIN: begin
				state_d = pse_pkg::S_RESP;
			end
			pse_pkg::S_READ_WAIT: begin
				state_d = pse_pkg::S_RESP;
			end
			pse_pkg::S_RESP: begin
				if (rsp_take) begin
					state_d = pse_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = pse_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= (state_q == pse_pkg::S_COLLECT);
			if (state_q == pse_pkg::S_IDLE && accept && operation == pse_pkg::OP_RUN) begin
				count_q <= '0;
			end else if (list_we) begin
				count_q <= count_q + pse_pkg::COUNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		val_s1 <= idx_q[pse_pkg::LIMIT_W-1:0];
		case (state_q)
			pse_pkg::S_IDLE: begin
				lim_q   <= lim_clamped;
				idx_q   <= '0;
				value_q <= '0;
				ok_q    <= 1'b0;
			end
			pse_pkg::S_FILL: begin
				idx_q <= idx_q + pse_pkg::IDX_W'(1);
				if (idx_q == lim_ext) begin
					base_q <= pse_pkg::ROOT_W'(2);
					sq_q   <= pse_pkg::IDX_W'(4);
				end
			end
			pse_pkg::S_OUTER_RD: begin
				if (sq_q > lim_ext) begin
					idx_q <= pse_pkg::IDX_W'(2);
				end
			end
			pse_pkg::S_OUTER_CHK: begin
				if (flag_rdata) begin
					idx_q <= sq_q;
				end else begin
					base_q <= base_q + pse_pkg::ROOT_W'(1);
					sq_q   <= sq_next;
				end
			end
			pse_pkg::S_STRIKE: begin
				if (idx_q > lim_ext) begin
					base_q <= base_q + pse_pkg::ROOT_W'(1);
					sq_q   <= sq_next;
				end else begin
					idx_q <= idx_q + base_ext;
				end
			end
			pse_pkg::S_COLLECT: begin
				idx_q <= idx_q + pse_pkg::IDX_W'(1);
			end
			pse_pkg::S_READ_WAIT: begin
				value_q <= list_rdata;
				ok_q    <= 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

// File: rtl/prime_sieve_engine_top.sv
// ----------------------------------------------------------------------------
// Prime sieve engine
// Sieve of Eratosthenes over a flag bitmap with a readable list of the primes
// found by the last run.
//
//   Channel   Handshake              Word
//   cmd       cmd_valid / cmd_stall  operation, limit, position
//   res       res_valid / res_stall  prime_count, prime_value, position_valid
//
// A run with limit L >= 2 (L clamped to MAX_LIMIT) fills the flags 0..L,
// checks each base up to sqrt(L) and strikes its multiples when it is still
// flagged, collects the surviving values into the list, then drains and
// posts the result. A run with L < 2 and a read outside the list go straight
// to the result register; a valid read first waits for the list RAM.
// Reset leaves both RAMs undefined; no clearing pass is needed. While a
// result waits under res_stall the block holds the next word in its final
// state, and cmd_stall is high whenever the sequencer is not idle.
// ----------------------------------------------------------------------------
module prime_sieve_engine_top #(
	parameter int MAX_LIMIT  = pse_pkg::DEF_MAX_LIMIT,
	parameter int LIST_DEPTH = pse_pkg::DEF_LIST_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	output logic                        cmd_stall,
	input  logic                        operation,
	input  logic [pse_pkg::LIMIT_W-1:0] limit,
	input  logic [pse_pkg::POS_W-1:0]   position,
	output logic                        res_valid,
	input  logic                        res_stall,
	output logic [pse_pkg::COUNT_W-1:0] prime_count,
	output logic [pse_pkg::VALUE_W-1:0] prime_value,
	output logic                        position_valid
);

	localparam int EFF_MAX    = (MAX_LIMIT < 4095) ? MAX_LIMIT : 4095;
	localparam int FLAG_DEPTH = EFF_MAX + 1;
	localparam int FLAG_AW    = $clog2(FLAG_DEPTH);
	localparam int LIST_CAP   = (LIST_DEPTH < pse_pkg::COUNT_MAX) ? LIST_DEPTH
	                                                             : pse_pkg::COUNT_MAX;
	localparam int LIST_AW    = $clog2(LIST_CAP);

	logic                        flag_we, flag_wdata, flag_re, flag_rdata;
	logic [FLAG_AW-1:0]          flag_waddr, flag_raddr;
	logic                        list_we, list_re;
	logic [LIST_AW-1:0]          list_waddr, list_raddr;
	logic [pse_pkg::VALUE_W-1:0] list_wdata, list_rdata;
	logic                        rsp_valid, rsp_take;
	pse_pkg::rsp_t               rsp;
	logic                        res_valid_q;

	pse_sieve_ctrl #(
		.MAX_LIMIT (MAX_LIMIT),
		.LIST_DEPTH(LIST_DEPTH),
		.FLAG_AW   (FLAG_AW),
		.LIST_AW   (LIST_AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.operation (operation),
		.limit     (limit),
		.position  (position),
		.flag_we   (flag_we),
		.flag_waddr(flag_waddr),
		.flag_wdata(flag_wdata),
		.flag_re   (flag_re),
		.flag_raddr(flag_raddr),
		.flag_rdata(flag_rdata),
		.list_we   (list_we),
		.list_waddr(list_waddr),
		.list_wdata(list_wdata),
		.list_re   (list_re),
		.list_raddr(list_raddr),
		.list_rdata(list_rdata),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.rsp_take  (rsp_take)
	);

	pse_ram #(
		.DEPTH(FLAG_DEPTH),
		.AW   (FLAG_AW),
		.DW   (1)
	) u_flag_ram (
		.clk  (clk),
		.we   (flag_we),
		.waddr(flag_waddr),
		.wdata(flag_wdata),
		.re   (flag_re),
		.raddr(flag_raddr),
		.rdata(flag_rdata)
	);

	pse_ram #(
		.DEPTH(LIST_CAP),
		.AW   (LIST_AW),
		.DW   (pse_pkg::VALUE_W)
	) u_list_ram (
		.clk  (clk),
		.we   (list_we),
		.waddr(list_waddr),
		.wdata(list_wdata),
		.re   (list_re),
		.raddr(list_raddr),
		.rdata(list_rdata)
	);

	// The result register takes a new word whenever it is empty or draining.
	assign rsp_take  = !res_valid_q || !res_stall;
	assign res_valid = res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (rsp_take) begin
			res_valid_q <= rsp_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_take && rsp_valid) begin
			prime_count    <= rsp.count;
			prime_value    <= rsp.value;
			position_valid <= rsp.ok;
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("sequencer took a word without leaving idle");

	a_valid_read_is_prime: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && position_valid |-> prime_value > pse_pkg::VALUE_W'(1))
		else $error("valid read returned a value below two");

	a_miss_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !position_valid |-> prime_value == '0)
		else $error("invalid read or run returned a nonzero value");

	a_valid_read_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && position_valid |-> prime_count != '0)
		else $error("valid read reported with an empty prime list");

endmodule

// File: test/tb_prime_sieve_engine_top.sv
// ----------------------------------------------------------------------------
// Prime sieve engine testbench
// Sends sieve runs and prime-list reads through the command channel and
// checks every result word against a behavioral sieve kept in step with the
// accepted commands. Covers empty and full-range limits, reads past the list,
// random traffic under three idling mixes, a long result hold-off that backs
// the block up, and a full drain between bursts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_prime_sieve_engine_top;

	localparam int SIEVE_TOP   = pse_pkg::DEF_MAX_LIMIT;
	localparam int LIST_SLOTS  = (pse_pkg::DEF_LIST_DEPTH < pse_pkg::COUNT_MAX)
	                             ? pse_pkg::DEF_LIST_DEPTH : pse_pkg::COUNT_MAX;
	localparam int HOLD_CYCLES = 1000;
	localparam int WATCH_LIMIT = 60000;
	localparam int TAIL_CYCLES = 20;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cmd_valid = 1'b0;
	logic                          cmd_stall;
	logic                          operation = pse_pkg::OP_RUN;
	logic [pse_pkg::LIMIT_W-1:0]   limit = '0;
	logic [pse_pkg::POS_W-1:0]     position = '0;
	logic                          res_valid;
	logic                          res_stall = 1'b0;
	logic [pse_pkg::COUNT_W-1:0]   prime_count;
	logic [pse_pkg::VALUE_W-1:0]   prime_value;
	logic                          position_valid;

	// Behavioral sieve state, advanced once per accepted command word.
	bit                            sieve_flag [0:SIEVE_TOP];
	logic [pse_pkg::VALUE_W-1:0]   prime_table [0:pse_pkg::DEF_LIST_DEPTH-1];
	int unsigned                   primes_found = 0;

	pse_pkg::rsp_t                 prime_replies [$];
	int                            fail_count = 0;
	int                            send_idle_pct = 0;
	int                            recv_idle_pct = 0;
	logic                          hold_toggle = 1'b0;

	prime_sieve_engine_top uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (cmd_valid),
		.cmd_stall      (cmd_stall),
		.operation      (operation),
		.limit          (limit),
		.position       (position),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.prime_count    (prime_count),
		.prime_value    (prime_value),
		.position_valid (position_valid)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic pse_pkg::rsp_t sieve_answer(input logic op,
		input logic [pse_pkg::LIMIT_W-1:0] lim, input logic [pse_pkg::POS_W-1:0] pos);
		pse_pkg::rsp_t reply;
		int unsigned   top;
		int unsigned   i;
		int unsigned   j;
		reply = '0;
		if (op == pse_pkg::OP_RUN) begin
			top = (lim > SIEVE_TOP) ? SIEVE_TOP : lim;
			primes_found = 0;
			if (top >= 2) begin
				for (i = 0; i <= top; i++)
					sieve_flag[i] = 1'b1;
				sieve_flag[0] = 1'b0;
				sieve_flag[1] = 1'b0;
				for (i = 2; i * i <= top; i++) begin
					if (sieve_flag[i]) begin
						for (j = i * i; j <= top; j += i)
							sieve_flag[j] = 1'b0;
					end
				end
				for (i = 2; i <= top; i++) begin
					if (sieve_flag[i] && primes_found < LIST_SLOTS) begin
						prime_table[primes_found] = i[pse_pkg::VALUE_W-1:0];
						primes_found++;
					end
				end
			end
		end else if (pos < primes_found && pos < pse_pkg::DEF_LIST_DEPTH) begin
			reply.value = prime_table[pos];
			reply.ok    = 1'b1;
		end
		reply.count = primes_found[pse_pkg::COUNT_W-1:0];
		return reply;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $time);
		fail_count++;
	endtask

	// Offers one word, with random gaps ahead of it, and records its answer
	// at the edge where the block takes it.
	task automatic send_word(input logic op, input logic [pse_pkg::LIMIT_W-1:0] lim,
		input logic [pse_pkg::POS_W-1:0] pos);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		operation <= op;
		limit     <= lim;
		position  <= pos;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		prime_replies.push_back(sieve_answer(op, lim, pos));
	endtask

	// The sender goes quiet until every expected word has come back.
	task automatic wait_for_drain();
		cmd_valid <= 1'b0;
		while (prime_replies.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_read_before_run();
		send_word(pse_pkg::OP_READ, 12'h000, 10'd0);
		send_word(pse_pkg::OP_READ, 12'hFFF, 10'd1023);
	endtask

	task automatic test_tiny_limits();
		send_word(pse_pkg::OP_RUN, 12'd0, 10'd0);
		send_word(pse_pkg::OP_READ, 12'd0, 10'd0);
		send_word(pse_pkg::OP_RUN, 12'd1, 10'd0);
		send_word(pse_pkg::OP_READ, 12'd0, 10'd0);
		send_word(pse_pkg::OP_RUN, 12'd2, 10'd0);
		send_word(pse_pkg::OP_READ, 12'd0, 10'd0);
		send_word(pse_pkg::OP_READ, 12'd0, 10'd1);
		send_word(pse_pkg::OP_RUN, 12'd4, 10'd0);
		send_word(pse_pkg::OP_READ, 12'd0, 10'd1);
	endtask

	task automatic test_full_range();
		send_word(pse_pkg::OP_RUN, 12'hFFF, 10'h3FF);
		send_word(pse_pkg::OP_READ, 12'd0, 10'd0);
		send_word(pse_pkg::OP_READ, 12'd0, 10'd512);
		send_word(pse_pkg::OP_READ, 12'd0, primes_found[pse_pkg::POS_W-1:0] - 10'd1);
		send_word(pse_pkg::OP_READ, 12'd0, primes_found[pse_pkg::POS_W-1:0]);
		send_word(pse_pkg::OP_READ, 12'd0, 10'd1023);
		// A run that finds nothing must hide the primes left in the list.
		send_word(pse_pkg::OP_RUN, 12'd0, 10'd0);
		send_word(pse_pkg::OP_READ, 12'd0, 10'd0);
	endtask

	task automatic test_random_mix(input int words);
		logic [pse_pkg::LIMIT_W-1:0] lim;
		logic [pse_pkg::POS_W-1:0]   pos;
		for (int n = 0; n < words; n++) begin
			lim = pse_pkg::LIMIT_W'($urandom);
			pos = pse_pkg::POS_W'($urandom);
			if ($urandom_range(99) < 25) begin
				// Mostly short runs; a full-width limit now and then.
				if ($urandom_range(19) != 0)
					lim = pse_pkg::LIMIT_W'($urandom_range(300));
				send_word(pse_pkg::OP_RUN, lim, pos);
			end else begin
				if (primes_found != 0 && $urandom_range(99) < 75)
					pos = pse_pkg::POS_W'($urandom_range(primes_found - 1));
				send_word(pse_pkg::OP_READ, lim, pos);
			end
		end
	endtask

	task automatic test_stalled_receiver();
		hold_toggle = ~hold_toggle;
		send_word(pse_pkg::OP_RUN, 12'd97, 10'd0);
		for (int n = 0; n < 6; n++)
			send_word(pse_pkg::OP_READ, pse_pkg::LIMIT_W'($urandom),
				pse_pkg::POS_W'($urandom_range(primes_found)));
	endtask

	task automatic test_drain_pause();
		send_word(pse_pkg::OP_RUN, 12'd60, 10'd0);
		send_word(pse_pkg::OP_READ, 12'd0, 10'd16);
		wait_for_drain();
		send_word(pse_pkg::OP_READ, 12'd0, 10'd17);
		send_word(pse_pkg::OP_READ, 12'd0, 10'd3);
	endtask

	// Receiver side: random stall, or a long hold-off when one is requested.
	logic hold_seen = 1'b0;
	int   hold_left = 0;
	always @(posedge clk) begin
		if (hold_toggle != hold_seen) begin
			hold_seen <= hold_toggle;
			hold_left <= HOLD_CYCLES;
			res_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			res_stall <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		pse_pkg::rsp_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (prime_replies.size() == 0) begin
				report_mismatch("word with none pending, count", int'(prime_count), 0);
			end else begin
				want = prime_replies.pop_front();
				if (prime_count !== want.count)
					report_mismatch("prime_count", int'(prime_count), int'(want.count));
				if (prime_value !== want.value)
					report_mismatch("prime_value", int'(prime_value), int'(want.value));
				if (position_valid !== want.ok)
					report_mismatch("position_valid", int'(position_valid),
						int'(want.ok));
			end
		end
	end

	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCH_LIMIT) begin
			$display("tb_prime_sieve_engine_top: errors");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_read_before_run();
		test_tiny_limits();
		test_full_range();

		send_idle_pct = 11;
		recv_idle_pct = 47;
		test_random_mix(24);
		test_stalled_receiver();

		send_idle_pct = 47;
		recv_idle_pct = 11;
		test_random_mix(23);
		test_drain_pause();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_mix(23);

		wait_for_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("tb_prime_sieve_engine_top: clean");
		else
			$display("tb_prime_sieve_engine_top: errors");
		$finish;
	end

endmodule
